// ===== src/tsi_pkg.sv =====
package tsi_pkg;

  localparam int DEPTH_PER_STACK_DEF = 64;
  localparam int NUM_STACKS = 3;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_STACK = 2'd3
  } status_t;

endpackage

// ===== src/tsi_ram.sv =====
module tsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/three_stacks_interleaved.sv =====
// A result is valid in the cycle after its item is transferred in.
// One item is taken per cycle while no result is stalled; the single result
// register and the one address used by both the write and read ports of the
// shared RAM set that rate, and a stalled result holds off the input.
// Reset (synchronous, active high) clears the three depth counts and the
// result valid; RAM contents stay undefined until pushed.
module three_stacks_interleaved #(
  parameter int DEPTH_PER_STACK = tsi_pkg::DEPTH_PER_STACK_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [1:0]                   stack_id,
  input  logic [tsi_pkg::VALUE_W-1:0]  push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tsi_pkg::VALUE_W-1:0]  top_value,
  output logic [1:0]                   status
);

  import tsi_pkg::*;

  localparam int DW = $clog2(DEPTH_PER_STACK + 1);
  localparam int STORE_WORDS = NUM_STACKS * DEPTH_PER_STACK;
  localparam int AW = $clog2(STORE_WORDS);

  logic [DW-1:0]      depth [NUM_STACKS];
  logic               fire;
  logic               bad;
  logic [1:0]         sid;
  logic [DW-1:0]      d_cur;
  logic [DW-1:0]      d_sel;
  logic [DW+1:0]      addr_wide;
  logic [AW-1:0]      addr;
  status_t            st_next;
  logic               we;
  logic               re;
  logic               inc;
  logic               dec;
  status_t            st_q;
  logic               peek_ok;
  logic [VALUE_W-1:0] rdata;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign bad   = stack_id > 2'(NUM_STACKS - 1);
  assign sid   = bad ? 2'd0 : stack_id;
  assign d_cur = depth[sid];
  assign d_sel = (cmd_t'(cmd) == CMD_PUSH) ? d_cur : d_cur - DW'(1);

  // Element d of stack k sits at 3*d + k.
  assign addr_wide = {1'b0, d_sel, 1'b0} + {2'b00, d_sel} + {DW'(0), sid};
  assign addr      = addr_wide[AW-1:0];

  always_comb begin
    st_next = ST_OK;
    we      = 1'b0;
    re      = 1'b0;
    inc     = 1'b0;
    dec     = 1'b0;
    if (bad) begin
      st_next = ST_BAD_STACK;
    end else begin
      unique case (cmd_t'(cmd))
        CMD_PUSH: begin
          if (d_cur == DW'(DEPTH_PER_STACK)) begin
            st_next = ST_FULL;
          end else begin
            we  = fire;
            inc = 1'b1;
          end
        end
        CMD_POP: begin
          if (d_cur == '0) begin
            st_next = ST_EMPTY;
          end else begin
            dec = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (d_cur == '0) begin
            st_next = ST_EMPTY;
          end else begin
            re = fire;
          end
        end
        default: st_next = ST_OK;
      endcase
    end
  end

  tsi_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (push_value),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        depth[i] <= '0;
      end
    end else if (fire && inc) begin
      depth[sid] <= d_cur + DW'(1);
    end else if (fire && dec) begin
      depth[sid] <= d_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_q    <= st_next;
      peek_ok <= re;
    end
  end

  assign status    = st_q;
  assign top_value = peek_ok ? rdata : '1;

  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_chk
    a_depth_range: assert property (@(posedge clk) disable iff (rst)
      depth[g] <= DW'(DEPTH_PER_STACK))
      else $error("stack depth out of range");

    a_push_inc: assert property (@(posedge clk) disable iff (rst)
      fire && !bad && sid == 2'(g) && cmd_t'(cmd) == CMD_PUSH && st_next == ST_OK
      |=> depth[g] == $past(depth[g]) + DW'(1))
      else $error("push did not advance depth");
  end

  a_err_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_t'(status) != ST_OK |-> top_value == '1)
    else $error("failed operation returned a value");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import tsi_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] STACK_BAD = 2'd3;
  localparam int DEPTH = DEPTH_PER_STACK_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int NUM_PHASES = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  sid;
    logic [31:0] val;
  } stack_req_t;

  typedef struct packed {
    logic [31:0] top;
    logic [1:0]  st;
  } stack_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_PUSH;
  logic [1:0]  stack_id = 2'd0;
  logic [31:0] push_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] top_value;
  logic [1:0]  status;

  stack_req_t  req_backlog[$];
  stack_resp_t awaited_resp[$];
  logic [31:0] shadow_mem[NUM_STACKS][DEPTH];
  int unsigned shadow_depth[NUM_STACKS] = '{0, 0, 0};
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          idle_tab[NUM_PHASES] = '{0, 63, 0, 23};
  int          stall_tab[NUM_PHASES] = '{0, 0, 63, 23};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_stacks_interleaved i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .stack_id   (stack_id),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .top_value  (top_value),
    .status     (status)
  );

  function automatic stack_resp_t stack_step(stack_req_t r);
    stack_resp_t res;
    int unsigned d;
    res.top = '1;
    res.st  = ST_OK;
    if (r.sid == STACK_BAD) begin
      res.st = ST_BAD_STACK;
    end else begin
      d = shadow_depth[r.sid];
      case (r.op)
        CMD_PUSH: begin
          if (d >= DEPTH) begin
            res.st = ST_FULL;
          end else begin
            shadow_mem[r.sid][d] = r.val;
            shadow_depth[r.sid] = d + 1;
          end
        end
        CMD_POP: begin
          if (d == 0) res.st = ST_EMPTY;
          else shadow_depth[r.sid] = d - 1;
        end
        CMD_PEEK: begin
          if (d == 0) res.st = ST_EMPTY;
          else res.top = shadow_mem[r.sid][d - 1];
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [1:0] sid, input logic [31:0] val);
    req_backlog.insert(req_backlog.size(), stack_req_t'{op, sid, val});
  endtask

  task automatic load_directed();
    add_req(CMD_POP, 2'd0, '0);
    add_req(CMD_PEEK, 2'd1, '0);
    add_req(CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
    add_req(CMD_PEEK, 2'd0, '0);
    add_req(CMD_PUSH, 2'd1, 32'h8000_0000);
    add_req(CMD_PEEK, 2'd1, '0);
    add_req(CMD_PUSH, 2'd2, 32'hFFFF_FFFF);
    add_req(CMD_PUSH, 2'd2, 32'h0000_0000);
    add_req(CMD_PEEK, 2'd2, '0);
    add_req(CMD_POP, 2'd2, '0);
    add_req(CMD_PEEK, 2'd2, '0);
    add_req(CMD_PUSH, STACK_BAD, 32'h1234_5678);
    add_req(CMD_POP, STACK_BAD, '0);
    add_req(CMD_PEEK, STACK_BAD, '0);
    add_req(CMD_UNUSED, STACK_BAD, '0);
    add_req(CMD_UNUSED, 2'd0, 32'hFFFF_FFFF);
    add_req(CMD_PUSH, 2'd0, 32'hA5A5_A5A5);
    add_req(CMD_PEEK, 2'd0, '0);
    add_req(CMD_POP, 2'd0, '0);
    add_req(CMD_PEEK, 2'd0, '0);
    add_req(CMD_POP, 2'd0, '0);
    add_req(CMD_POP, 2'd0, '0);
    add_req(CMD_PEEK, 2'd0, '0);
  endtask

  // fill and drain bursts drive stacks to full and empty; the rest is noise
  task automatic gen_bursts(input int n);
    int made;
    int len;
    int kind;
    logic [1:0] sid;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(9);
      sid  = 2'($urandom_range(2));
      len  = $urandom_range(8, 70);
      if (len > n - made) len = n - made;
      for (int i = 0; i < len; i++) begin
        if (kind >= 7 || $urandom_range(9) == 0) begin
          add_req(2'($urandom_range(3)), 2'($urandom_range(3)), rand_word());
        end else if ($urandom_range(4) == 0) begin
          add_req(CMD_PEEK, sid, rand_word());
        end else if (kind < 4) begin
          add_req(CMD_PUSH, sid, rand_word());
        end else begin
          add_req(CMD_POP, sid, rand_word());
        end
      end
      made += len;
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || awaited_resp.size() != 0);
  endtask

  always @(posedge clk) begin
    stack_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        in_valid   <= 1'b1;
        cmd        <= nxt.op;
        stack_id   <= nxt.sid;
        push_value <= nxt.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    stack_resp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_resp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual top_value %h status %0d",
                   $time, top_value, status);
        end else begin
          want = awaited_resp.pop_front();
          if (top_value !== want.top) begin
            mismatches++;
            $display("%0t: top_value expected %h actual %h", $time, want.top, top_value);
          end
          if (status !== want.st) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_resp.insert(awaited_resp.size(),
                            stack_step(stack_req_t'{cmd, stack_id, push_value}));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    load_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      gen_bursts(ITEMS_PER_PHASE);
      drain();
    end
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tsi_pkg.sv
src/tsi_ram.sv
src/three_stacks_interleaved.sv
tb/tb_top.sv
